// File: hdl/vau_pkg.sv
package vau_pkg;

  localparam int FIELD_BITS = 32;
  localparam int OPND_BITS  = 33;
  localparam int IN_BITS    = 232;
  localparam int OUT_BITS   = 136;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = 2;

  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_SUB   = 4'd1,
    MODE_MUL   = 4'd2,
    MODE_LERP  = 4'd3,
    MODE_DOT   = 4'd4,
    MODE_CROSS = 4'd5,
    MODE_MAG   = 4'd6,
    MODE_DIST  = 4'd7,
    MODE_NORM  = 4'd8,
    MODE_SCALE = 4'd9
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                         mode;
    logic [2:0][OPND_BITS-1:0]     a;
    logic [2:0][OPND_BITS-1:0]     b;
    logic [2:0][OPND_BITS-1:0]     x0;
    logic [2:0][OPND_BITS-1:0]     y0;
    logic [2:0][OPND_BITS-1:0]     x1;
    logic [2:0][OPND_BITS-1:0]     y1;
  } vau_op_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } vau_hs_t;

endpackage

// File: hdl/vau_front.sv
module vau_front #(
  parameter int DATA_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [vau_pkg::IN_BITS-1:0]   s_data_i,
  output vau_pkg::vau_hs_t              op_hs_o,
  input  logic                          op_ready_i,
  output vau_pkg::vau_op_t              op_o
);
  import vau_pkg::*;

  localparam int W = (DATA_BITS > FIELD_BITS) ? FIELD_BITS : DATA_BITS;

  logic    valid_q, valid_d;
  vau_op_t op_q, op_d;
  logic signed [OPND_BITS-1:0] a [3];
  logic signed [OPND_BITS-1:0] b [3];
  logic signed [OPND_BITS-1:0] f;

  function automatic logic [OPND_BITS-1:0] ext_w(logic [FIELD_BITS-1:0] v);
    logic [OPND_BITS-1:0] o;
    for (int k = 0; k < OPND_BITS; k++) begin
      o[k] = v[(k < W) ? k : W - 1];
    end
    return o;
  endfunction

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      a[l] = ext_w(s_data_i[4 + 32*l +: 32]);
      b[l] = ext_w(s_data_i[100 + 32*l +: 32]);
    end
    f = ext_w(s_data_i[196 +: 32]);
    op_d = '0;
    op_d.mode = mode_e'(s_data_i[3:0]);
    for (int l = 0; l < 3; l++) begin
      op_d.a[l] = a[l];
      op_d.b[l] = b[l];
    end
    case (op_d.mode)
      MODE_MUL, MODE_DOT: begin
        for (int l = 0; l < 3; l++) begin
          op_d.x0[l] = a[l];
          op_d.y0[l] = b[l];
        end
      end
      MODE_LERP: begin
        for (int l = 0; l < 3; l++) begin
          op_d.x0[l] = b[l] - a[l];
          op_d.y0[l] = f;
        end
      end
      MODE_SCALE: begin
        for (int l = 0; l < 3; l++) begin
          op_d.x0[l] = a[l];
          op_d.y0[l] = f;
        end
      end
      MODE_CROSS: begin
        op_d.x0[0] = a[1]; op_d.y0[0] = b[2]; op_d.x1[0] = a[2]; op_d.y1[0] = b[1];
        op_d.x0[1] = a[2]; op_d.y0[1] = b[0]; op_d.x1[1] = a[0]; op_d.y1[1] = b[2];
        op_d.x0[2] = a[0]; op_d.y0[2] = b[1]; op_d.x1[2] = a[1]; op_d.y1[2] = b[0];
      end
      MODE_MAG, MODE_NORM: begin
        for (int l = 0; l < 3; l++) begin
          op_d.x0[l] = a[l];
          op_d.y0[l] = a[l];
        end
      end
      MODE_DIST: begin
        for (int l = 0; l < 3; l++) begin
          op_d.x0[l] = a[l] - b[l];
          op_d.y0[l] = a[l] - b[l];
        end
      end
      default: begin
      end
    endcase
  end

  assign s_ready_o = !valid_q || op_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      op_q <= op_d;
    end
  end

  assign op_hs_o.valid = valid_q;
  assign op_hs_o.ready = s_ready_o;
  assign op_o = op_q;

endmodule

// File: hdl/vau_queue.sv
module vau_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vau_pkg::vau_hs_t  push_hs_i,
  output logic              push_ready_o,
  input  vau_pkg::vau_op_t  push_op_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output vau_pkg::vau_op_t  pop_op_o
);
  import vau_pkg::*;

  vau_op_t mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QUEUE_PTR_BITS:0]   cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != QUEUE_PTR_BITS'(0) + (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push = push_hs_i.valid && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_op_o = mem[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_q] <= push_op_i;
    end
  end

endmodule

// File: hdl/vau_back.sv
module vau_back #(
  parameter int DATA_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          op_valid_i,
  output logic                          op_ready_o,
  input  vau_pkg::vau_op_t              op_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vau_pkg::OUT_BITS-1:0]  out_data_o
);
  import vau_pkg::*;

  localparam int W   = (DATA_BITS > FIELD_BITS) ? FIELD_BITS : DATA_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NST = 1 + W + F + 1;
  localparam logic signed [67:0] WMAXL = (68'sd1 <<< (W - 1)) - 68'sd1;
  localparam logic signed [67:0] WMINL = -WMAXL - 68'sd1;

  typedef struct packed {
    mode_e                 mode;
    logic                  ov;
    logic [2:0][W-1:0]     r;
    logic [W-1:0]          sc;
    logic [2*W-1:0]        rad;
    logic [W-1:0]          root;
    logic [W+1:0]          rem;
    logic [2:0][W-1:0]     mag;
    logic [2:0]            neg;
    logic [2:0][W-1:0]     drem;
    logic [2:0][F:0]       quo;
  } stg_t;

  function automatic logic [W-1:0] sat_w(logic signed [67:0] v);
    if (v > WMAXL) return WMAXL[W-1:0];
    if (v < WMINL) return WMINL[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic is_ovf(logic signed [67:0] v);
    return (v > WMAXL) || (v < WMINL);
  endfunction

  function automatic stg_t sqrt_step(stg_t s);
    stg_t o;
    logic [W+1:0] r2, tr;
    o  = s;
    r2 = {s.rem[W-1:0], s.rad[2*W-1 -: 2]};
    tr = {s.root, 2'b01};
    if (r2 >= tr) begin
      o.rem  = r2 - tr;
      o.root = {s.root[W-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[W-2:0], 1'b0};
    end
    o.rad = s.rad << 2;
    return o;
  endfunction

  function automatic stg_t div_step(stg_t s, logic first);
    stg_t o;
    logic [W:0] r2;
    o = s;
    for (int l = 0; l < 3; l++) begin
      r2 = {s.drem[l], first ? s.mag[l][0] : 1'b0};
      if (r2 >= {1'b0, s.root}) begin
        o.drem[l] = W'(r2 - {1'b0, s.root});
        o.quo[l]  = {s.quo[l][F-1:0], 1'b1};
      end else begin
        o.drem[l] = r2[W-1:0];
        o.quo[l]  = {s.quo[l][F-1:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic logic [FIELD_BITS-1:0] ext32(logic [W-1:0] v);
    logic [FIELD_BITS-1:0] o;
    for (int k = 0; k < FIELD_BITS; k++) begin
      o[k] = v[(k < W) ? k : W - 1];
    end
    return o;
  endfunction

  logic adv;
  logic v1_q, v2_q, vo_q;
  logic v_q [NST];

  mode_e mode1_q, mode2_q;
  logic signed [OPND_BITS-1:0] a1_q [3], b1_q [3], a2_q [3], b2_q [3];
  logic signed [65:0] p0_1_q [3], p1_1_q [3];
  logic signed [66:0] v2_q_d [3], val2_q [3];
  logic signed [67:0] sum2_d, sum2_q;

  stg_t st_q [NST];
  stg_t nxt  [NST];

  logic [2:0][W-1:0] ro_d, ro_q;
  logic [W-1:0]      so_d, so_q;
  status_e           sto_d, sto_q;

  assign adv        = !vo_q || out_ready_i;
  assign op_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
      for (int k = 0; k < NST; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_q <= op_valid_i;
      v2_q <= v1_q;
      v_q[0] <= v2_q;
      for (int k = 1; k < NST; k++) begin
        v_q[k] <= v_q[k-1];
      end
      vo_q <= v_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode1_q <= op_i.mode;
      for (int l = 0; l < 3; l++) begin
        a1_q[l]   <= $signed(op_i.a[l]);
        b1_q[l]   <= $signed(op_i.b[l]);
        p0_1_q[l] <= $signed(op_i.x0[l]) * $signed(op_i.y0[l]);
        p1_1_q[l] <= $signed(op_i.x1[l]) * $signed(op_i.y1[l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (mode1_q == MODE_CROSS) begin
        v2_q_d[l] = 67'(p0_1_q[l]) - 67'(p1_1_q[l]);
      end else begin
        v2_q_d[l] = 67'(p0_1_q[l]);
      end
    end
    sum2_d = 68'(p0_1_q[0]) + 68'(p0_1_q[1]) + 68'(p0_1_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode2_q <= mode1_q;
      sum2_q  <= sum2_d;
      for (int l = 0; l < 3; l++) begin
        a2_q[l]   <= a1_q[l];
        b2_q[l]   <= b1_q[l];
        val2_q[l] <= v2_q_d[l];
      end
    end
  end

  always_comb begin
    logic signed [67:0] t;
    logic signed [OPND_BITS-1:0] ab;
    nxt[0] = '0;
    nxt[0].mode = mode2_q;
    for (int l = 0; l < 3; l++) begin
      case (mode2_q)
        MODE_ADD:                      t = 68'(a2_q[l]) + 68'(b2_q[l]);
        MODE_SUB:                      t = 68'(a2_q[l]) - 68'(b2_q[l]);
        MODE_MUL, MODE_SCALE, MODE_CROSS: t = 68'(val2_q[l] >>> F);
        MODE_LERP:                     t = 68'(a2_q[l]) + 68'(val2_q[l] >>> F);
        default:                       t = '0;
      endcase
      nxt[0].r[l] = sat_w(t);
      if (is_ovf(t)) begin
        nxt[0].ov = 1'b1;
      end
      ab = (a2_q[l] < 0) ? -a2_q[l] : a2_q[l];
      nxt[0].mag[l]  = ab[W-1:0];
      nxt[0].neg[l]  = a2_q[l] < 0;
      nxt[0].drem[l] = ab[W-1:0] >> 1;
    end
    nxt[0].rad = sum2_q[2*W-1:0];
    case (mode2_q)
      MODE_DOT: begin
        t = sum2_q >>> F;
        nxt[0].sc = sat_w(t);
        if (is_ovf(t)) begin
          nxt[0].ov = 1'b1;
        end
      end
      MODE_MAG, MODE_DIST: begin
        if ((sum2_q >>> (2*W - 2)) != 68'sd0) begin
          nxt[0].ov = 1'b1;
          nxt[0].sc = WMAXL[W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 1; k < NST; k++) begin : g_stage
    if (k <= W) begin : g_sqrt
      assign nxt[k] = sqrt_step(st_q[k-1]);
    end else begin : g_div
      assign nxt[k] = div_step(st_q[k-1], k == W + 1);
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k] <= nxt[k];
      end
    end
  end

  always_comb begin
    stg_t s;
    logic signed [67:0] qs;
    logic ov;
    s     = st_q[NST-1];
    ov    = s.ov;
    ro_d  = s.r;
    so_d  = s.sc;
    sto_d = ST_OK;
    case (s.mode)
      MODE_NORM: begin
        if (s.root == '0) begin
          ro_d  = '0;
          sto_d = ST_DIVZ;
        end else begin
          for (int l = 0; l < 3; l++) begin
            qs = 68'(s.quo[l]);
            if (s.neg[l]) begin
              qs = -qs;
            end
            ro_d[l] = sat_w(qs);
            if (is_ovf(qs)) begin
              ov = 1'b1;
            end
          end
        end
      end
      MODE_MAG, MODE_DIST: begin
        if (!s.ov) begin
          so_d = s.root;
        end
      end
      default: begin
      end
    endcase
    if (sto_d == ST_OK && ov) begin
      sto_d = ST_SAT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ro_q  <= ro_d;
      so_q  <= so_d;
      sto_q <= sto_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = {6'd0, sto_q, ext32(so_q), ext32(ro_q[2]), ext32(ro_q[1]),
                        ext32(ro_q[0])};

endmodule

// File: hdl/vec3_arithmetic_unit_core.sv
// Channel  | Direction | Payload (tdata, lowest bit first)
// s_axis   | in        | mode[3:0], a_x, a_y, a_z, b_x, b_y, b_z, factor, 4 zero bits
// m_axis   | out       | r_x, r_y, r_z, scalar, status[1:0], 6 zero bits
//
// One request is accepted per cycle while the output side keeps up.
// The execution pipeline depth is set by the one-bit-per-stage square root and the
// normalize divider pipelines.
// A four-entry queue parts the input register from the execution pipeline.
// When the output register is held, the whole execution pipeline stalls.
// Reset clears all valid flags; no clearing pass is needed.
module vec3_arithmetic_unit_core #(
  parameter int DATA_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // mode, a_x, a_y, a_z, b_x, b_y, b_z, factor
  input  logic [vau_pkg::IN_BITS-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // r_x, r_y, r_z, scalar, status
  output logic [vau_pkg::OUT_BITS-1:0]  m_axis_tdata_o
);
  import vau_pkg::*;

  vau_hs_t fe_hs;
  vau_op_t fe_op, q_op;
  logic    q_ready, q_valid, be_ready;

  vau_front #(
    .DATA_BITS(DATA_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .op_hs_o   (fe_hs),
    .op_ready_i(q_ready),
    .op_o      (fe_op)
  );

  vau_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_hs_i   (fe_hs),
    .push_ready_o(q_ready),
    .push_op_i   (fe_op),
    .pop_valid_o (q_valid),
    .pop_ready_i (be_ready),
    .pop_op_o    (q_op)
  );

  vau_back #(
    .DATA_BITS(DATA_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_ready_o (be_ready),
    .op_i       (q_op),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[129:128] == ST_DIVZ) |->
      m_axis_tdata_o[127:0] == '0)
    else $error("zero-vector normalize must give zero results");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[127:96] != '0) |-> m_axis_tdata_o[95:0] == '0)
    else $error("scalar result with nonzero vector result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fe_hs.valid && !q_ready) |=> fe_hs.valid)
    else $error("front request lost while queue was full");

endmodule

// File: test/vec3_arithmetic_unit_core_tb.sv
`timescale 1ns / 1ps

module vec3_arithmetic_unit_core_tb;
  import vau_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_BITS-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata_o;

  logic [IN_BITS-1:0] pending_reqs[$];
  logic [OUT_BITS-1:0] expected_results[$];
  bit in_took = 1'b0;
  bit hold_sender = 1'b0;
  bit quiet = 1'b0;
  int send_idle = 0;
  int recv_stall = 0;
  int errors = 0;
  int idle_cycles = 0;

  vec3_arithmetic_unit_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] clamp(input wide_t v, inout bit ovf);
    if (v > wide_t'(32'sh7FFFFFFF)) begin
      ovf = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -wide_t'(33'sh080000000)) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] probe;
    root = '0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] norm_sq(input wide_t x, input wide_t y, input wide_t z);
    wide_t acc;
    wide_t v[3];
    v[0] = x;
    v[1] = y;
    v[2] = z;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      if (v[i] < 0) v[i] = -v[i];
      acc = acc + v[i] * v[i];
    end
    if (acc > wide_t'(64'hFFFFFFFFFFFFFFFF)) return 64'hFFFFFFFFFFFFFFFF;
    return acc[63:0];
  endfunction

  function automatic logic [OUT_BITS-1:0] vector_result(input logic [IN_BITS-1:0] req);
    wide_t a[3];
    wide_t b[3];
    wide_t f;
    wide_t t;
    wide_t q;
    logic [31:0] r[3];
    logic [31:0] sc;
    logic [63:0] m;
    status_e st;
    bit ovf;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(req[4 + 32*i +: 32]);
      b[i] = $signed(req[100 + 32*i +: 32]);
      r[i] = '0;
    end
    f = $signed(req[196 +: 32]);
    sc = '0;
    st = ST_OK;
    ovf = 1'b0;
    case (mode_e'(req[3:0]))
      MODE_ADD: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] + b[i], ovf);
      MODE_SUB: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] - b[i], ovf);
      MODE_MUL: for (int i = 0; i < 3; i++) r[i] = clamp((a[i] * b[i]) >>> FRAC, ovf);
      MODE_LERP: begin
        for (int i = 0; i < 3; i++) r[i] = clamp(a[i] + (((b[i] - a[i]) * f) >>> FRAC), ovf);
      end
      MODE_DOT: begin
        t = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        sc = clamp(t >>> FRAC, ovf);
      end
      MODE_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          t = a[(i + 1) % 3] * b[(i + 2) % 3] - a[(i + 2) % 3] * b[(i + 1) % 3];
          r[i] = clamp(t >>> FRAC, ovf);
        end
      end
      MODE_MAG, MODE_DIST: begin
        if (req[3:0] == MODE_MAG) m = int_sqrt(norm_sq(a[0], a[1], a[2]));
        else m = int_sqrt(norm_sq(a[0] - b[0], a[1] - b[1], a[2] - b[2]));
        sc = clamp(wide_t'({64'd0, m}), ovf);
      end
      MODE_NORM: begin
        m = int_sqrt(norm_sq(a[0], a[1], a[2]));
        if (m == 0) begin
          st = ST_DIVZ;
        end else begin
          for (int i = 0; i < 3; i++) begin
            q = ((a[i] < 0 ? -a[i] : a[i]) <<< FRAC) / wide_t'({64'd0, m});
            r[i] = clamp(a[i] < 0 ? -q : q, ovf);
          end
        end
      end
      MODE_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp((a[i] * f) >>> FRAC, ovf);
      default: ;
    endcase
    if (st == ST_OK && ovf) st = ST_SAT;
    return {6'd0, st, sc, r[2], r[1], r[0]};
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    logic [OUT_BITS-1:0] want;
    in_took <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) expected_results.push_back(vector_result(s_axis_tdata_i));
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", m_axis_tdata_o[31:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata_o[31:0] !== want[31:0]) report("r_x", m_axis_tdata_o[31:0], want[31:0]);
          if (m_axis_tdata_o[63:32] !== want[63:32]) report("r_y", m_axis_tdata_o[63:32], want[63:32]);
          if (m_axis_tdata_o[95:64] !== want[95:64]) report("r_z", m_axis_tdata_o[95:64], want[95:64]);
          if (m_axis_tdata_o[127:96] !== want[127:96]) begin
            report("scalar", m_axis_tdata_o[127:96], want[127:96]);
          end
          if (m_axis_tdata_o[135:128] !== want[135:128]) begin
            report("status", 32'(m_axis_tdata_o[135:128]), 32'(want[135:128]));
          end
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(negedge clk_i) begin
    logic next_valid;
    logic [IN_BITS-1:0] next_data;
    next_valid = s_axis_tvalid_i;
    next_data = s_axis_tdata_i;
    if (rst_ni && (!s_axis_tvalid_i || in_took)) begin
      next_valid = 1'b0;
      if (send_idle > 0) begin
        send_idle--;
      end else if (pending_reqs.size() > 0 && !hold_sender) begin
        next_valid = 1'b1;
        next_data = pending_reqs.pop_front();
        if (!quiet && $urandom_range(0, 9) == 0) send_idle = $urandom_range(1, 13);
      end
    end
    s_axis_tvalid_i <= next_valid;
    s_axis_tdata_i <= next_data;
    if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (!quiet && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 13);
      m_axis_tready_i <= rst_ni;
    end
  end

  function automatic logic [31:0] pick_word();
    logic [31:0] edges[6] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h1, 32'hFFFFFFFF, 32'h00010000};
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
      4: return edges[$urandom_range(0, 5)];
      default: return $urandom_range(0, 32'h0FFFFFFF) - 32'h08000000;
    endcase
  endfunction

  function automatic logic [IN_BITS-1:0] make_req(input logic [3:0] mode, input logic [31:0] ax,
      input logic [31:0] ay, input logic [31:0] az, input logic [31:0] bx, input logic [31:0] by,
      input logic [31:0] bz, input logic [31:0] f);
    return {4'd0, f, bz, by, bx, az, ay, ax, mode};
  endfunction

  task automatic add_random(input int count);
    logic [3:0] mode;
    for (int n = 0; n < count; n++) begin
      mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      if (mode == MODE_NORM && $urandom_range(0, 9) == 0) begin
        pending_reqs.push_back(make_req(mode, 0, 0, 0, pick_word(), pick_word(), pick_word(),
                                        pick_word()));
      end else begin
        pending_reqs.push_back(make_req(mode, pick_word(), pick_word(), pick_word(), pick_word(),
                                        pick_word(), pick_word(), pick_word()));
      end
    end
  endtask

  initial begin
    for (int m = 0; m < 10; m++) begin
      pending_reqs.push_back(make_req(4'(m), $urandom, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom));
    end
    pending_reqs.push_back(make_req(MODE_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h7FFFFFFF,
                                    32'h80000000, 32'h0, 32'h0));
    pending_reqs.push_back(make_req(MODE_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h1, 32'h7FFFFFFF,
                                    32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF));
    pending_reqs.push_back(make_req(MODE_MUL, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                    32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h0));
    pending_reqs.push_back(make_req(MODE_LERP, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF,
                                    32'h80000000, 32'h0, 32'h80000000));
    pending_reqs.push_back(make_req(MODE_DOT, 32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h80000000, 32'h80000000, 32'h80000000, 32'h0));
    pending_reqs.push_back(make_req(MODE_CROSS, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                    32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h0));
    pending_reqs.push_back(make_req(MODE_MAG, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0,
                                    0));
    pending_reqs.push_back(make_req(MODE_DIST, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                    32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0));
    pending_reqs.push_back(make_req(MODE_NORM, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                    32'hFFFFFFFF));
    pending_reqs.push_back(make_req(MODE_NORM, 32'h80000000, 32'h0, 32'h0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(MODE_NORM, 32'h1, 32'hFFFFFFFF, 32'h1, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(MODE_SCALE, 32'h7FFFFFFF, 32'h80000000, 32'h12345678, 0, 0, 0,
                                    32'h80000000));
    pending_reqs.push_back(make_req(4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    pending_reqs.push_back(make_req(4'd10, 1, 2, 3, 4, 5, 6, 7));
    add_random(700);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0 && !s_axis_tvalid_i);
    hold_sender = 1'b0;
    add_random(500);
    wait (pending_reqs.size() == 0);
    quiet = 1'b1;
    add_random(200);
    wait (pending_reqs.size() == 0 && !s_axis_tvalid_i);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: vec3_arithmetic_unit_core.f
hdl/vau_pkg.sv
hdl/vau_front.sv
hdl/vau_queue.sv
hdl/vau_back.sv
hdl/vec3_arithmetic_unit_core.sv
test/vec3_arithmetic_unit_core_tb.sv
